@@ src/btmx_pkg.sv @@
// Package for the binary trie max-xor multiset block.
// Holds sizes, operation and status codes, and the queue entry type. No dependencies.
package btmx_pkg;

   localparam int KEY_BITS   = 32;
   localparam int NODES      = 4096;
   localparam int COUNT_BITS = 16;
   localparam int NODE_BITS  = $clog2(NODES);
   localparam int FREE_BITS  = $clog2(NODES + 1);
   localparam int LVL_BITS   = $clog2(KEY_BITS + 1);
   localparam int QDEPTH     = 2;
   localparam int QPTR_BITS  = 1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_REMOVE = 2'd1,
      KIND_QUERY  = 2'd2,
      KIND_NONE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_ABSENT  = 2'd2,
      ST_EMPTY   = 2'd3
   } status_type;

   typedef struct packed {
      kind_type               kind;
      logic [KEY_BITS-1:0]    key;
   } cmd_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_CHECK_RD,
      S_CHECK_WT,
      S_CHECK,
      S_APPLY_RD,
      S_APPLY_WT,
      S_APPLY,
      S_DONE
   } state_type;

endpackage

@@ src/btmx_front.sv @@
// Front end of the trie block: accepts request transfers, decodes the kind
// and holds them in a short queue for the back end. Uses btmx_pkg.
module btmx_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [1:0]           req_tuser,
   input  logic [31:0]          req_tdata,
   output logic                 cmd_valid,
   input  logic                 cmd_ready,
   output btmx_pkg::cmd_type    cmd
);

   btmx_pkg::cmd_type                 q_ff [btmx_pkg::QDEPTH];
   logic [btmx_pkg::QPTR_BITS-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [btmx_pkg::QPTR_BITS:0]      cnt_ff, cnt_in;
   logic                              push, pop;
   btmx_pkg::cmd_type                 incoming;

   always_comb begin
      incoming.kind = btmx_pkg::kind_type'(req_tuser);
      incoming.key  = req_tdata[btmx_pkg::KEY_BITS-1:0];
   end

   assign req_tready = (cnt_ff != (btmx_pkg::QPTR_BITS+1)'(btmx_pkg::QDEPTH));
   assign cmd_valid  = (cnt_ff != '0);
   assign cmd        = q_ff[rd_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = cmd_valid && cmd_ready;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {{btmx_pkg::QPTR_BITS{1'b0}}, push} - {{btmx_pkg::QPTR_BITS{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= incoming;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (btmx_pkg::QPTR_BITS+1)'(btmx_pkg::QDEPTH))
      else $error("queue count overflow");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != '0)
      else $error("pop from empty queue");
   a_cnt_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 1'b1)
      else $error("queue count did not advance");
`endif

endmodule

@@ src/btmx_back.sv @@
// Back end of the trie block: walks the node pool in block memory, one level
// at a time, for add, remove and query. Uses btmx_pkg.
module btmx_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   output logic                 cmd_ready,
   input  btmx_pkg::cmd_type    cmd,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [39:0]          rsp_tdata
);

   localparam int NB = btmx_pkg::NODE_BITS;
   localparam int CB = btmx_pkg::COUNT_BITS;
   localparam int KB = btmx_pkg::KEY_BITS;
   localparam int LB = btmx_pkg::LVL_BITS;
   localparam int FB = btmx_pkg::FREE_BITS;

   // Node memory: {zero link, one link, count} in one word.
   logic [2*NB+CB-1:0]  mem [btmx_pkg::NODES];
   logic [2*NB+CB-1:0]  rd_data_ff;
   logic [NB-1:0]       rd_addr;
   logic                we;
   logic [NB-1:0]       wr_addr;
   logic [2*NB+CB-1:0]  wr_data;

   btmx_pkg::state_type state_ff, state_in;
   btmx_pkg::cmd_type   cur_ff, cur_in;
   logic [NB-1:0]       node_ff, node_in;
   logic [LB-1:0]       lvl_ff, lvl_in;       // remaining levels
   logic [FB-1:0]       free_ff, free_in;
   logic [FB-1:0]       init_ff, init_in;
   logic [KB-1:0]       acc_ff, acc_in;
   logic                first_ff, first_in;   // query root check pending
   logic                bad_ff, bad_in;
   logic                out_v_ff, out_v_in;
   logic [KB-1:0]       out_x_ff, out_x_in;
   btmx_pkg::status_type out_s_ff, out_s_in;

   logic [NB-1:0]       lz, lo;
   logic [CB-1:0]       lc;
   logic [LB-1:0]       bidx;
   logic                kb;
   logic [NB-1:0]       cand;
   logic [NB-1:0]       alloc;
   // Child count check needs a second read: keep parent data.
   logic [2*NB+CB-1:0]  par_ff, par_in;
   logic                opp_try_ff, opp_try_in;

   assign {lz, lo, lc} = rd_data_ff;
   assign bidx  = lvl_ff - 1'b1;
   assign kb    = cur_ff.key[bidx[$clog2(KB)-1:0]];
   assign alloc = free_ff[NB-1:0];

   always_ff @(posedge clock) begin
      if (we) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {6'd0, out_s_ff, out_x_ff};

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      node_in   = node_ff;
      lvl_in    = lvl_ff;
      free_in   = free_ff;
      init_in   = init_ff;
      acc_in    = acc_ff;
      first_in  = first_ff;
      bad_in    = bad_ff;
      par_in    = par_ff;
      opp_try_in = opp_try_ff;
      out_v_in  = out_v_ff && !rsp_tready;
      out_x_in  = out_x_ff;
      out_s_in  = out_s_ff;
      cmd_ready = 1'b0;
      rd_addr   = node_ff;
      we        = 1'b0;
      wr_addr   = node_ff;
      wr_data   = rd_data_ff;
      cand      = '0;
      case (state_ff)
         btmx_pkg::S_INIT: begin
            // Clearing pass seeds the key-zero path and nulls the rest.
            we      = 1'b1;
            wr_addr = init_ff[NB-1:0];
            if (init_ff < FB'(KB))
               wr_data = {NB'(init_ff + 1'b1), {NB{1'b0}},
                          (init_ff == '0) ? {CB{1'b0}} : CB'(1)};
            else if (init_ff == FB'(KB))
               wr_data = {{2*NB{1'b0}}, CB'(1)};
            else
               wr_data = '0;
            init_in = init_ff + 1'b1;
            if (init_ff == FB'(btmx_pkg::NODES - 1)) state_in = btmx_pkg::S_IDLE;
         end
         btmx_pkg::S_IDLE: begin
            if (!out_v_ff || rsp_tready) begin
               cmd_ready = 1'b1;
               if (cmd_valid) begin
                  cur_in   = cmd;
                  node_in  = '0;
                  lvl_in   = LB'(KB);
                  acc_in   = '0;
                  bad_in   = 1'b0;
                  first_in = 1'b1;
                  opp_try_in = 1'b0;
                  if (cmd.kind == btmx_pkg::KIND_NONE) begin
                     out_v_in = 1'b1; out_x_in = '0; out_s_in = btmx_pkg::ST_OK;
                  end else begin
                     state_in = btmx_pkg::S_CHECK_RD;
                  end
               end
            end
         end
         btmx_pkg::S_CHECK_RD: begin
            rd_addr  = node_ff;
            state_in = btmx_pkg::S_CHECK_WT;
         end
         btmx_pkg::S_CHECK_WT: begin
            state_in = btmx_pkg::S_CHECK;
         end
         btmx_pkg::S_CHECK: begin
            // rd_data_ff holds node_ff (or a child when opp_try_ff is set).
            case (cur_ff.kind)
               btmx_pkg::KIND_ADD: begin
                  cand = kb ? lo : lz;
                  if (cand == '0) begin
                     lvl_in = '0;
                  end else begin
                     node_in = cand;
                     lvl_in  = lvl_ff - 1'b1;
                  end
                  if (cand == '0 || lvl_ff == LB'(1)) begin
                     if ({1'b0, free_ff} + (FB+1)'(cand == '0 ? lvl_ff : '0)
                         > (FB+1)'(btmx_pkg::NODES)) begin
                        out_v_in = 1'b1; out_x_in = '0; out_s_in = btmx_pkg::ST_FULL;
                        state_in = btmx_pkg::S_IDLE;
                     end else begin
                        node_in = '0; lvl_in = LB'(KB);
                        state_in = btmx_pkg::S_APPLY_RD;
                     end
                  end else begin
                     state_in = btmx_pkg::S_CHECK_RD;
                  end
               end
               btmx_pkg::KIND_REMOVE: begin
                  if (opp_try_ff) begin
                     // rd_data_ff is the child: check its count.
                     opp_try_in = 1'b0;
                     if (lc == '0) begin
                        out_v_in = 1'b1; out_x_in = '0; out_s_in = btmx_pkg::ST_ABSENT;
                        state_in = btmx_pkg::S_IDLE;
                     end else if (lvl_ff == LB'(1)) begin
                        node_in = '0; lvl_in = LB'(KB);
                        state_in = btmx_pkg::S_APPLY_RD;
                     end else begin
                        lvl_in = lvl_ff - 1'b1;
                        state_in = btmx_pkg::S_CHECK;
                     end
                  end else begin
                     cand = kb ? lo : lz;
                     if (cand == '0) begin
                        out_v_in = 1'b1; out_x_in = '0; out_s_in = btmx_pkg::ST_ABSENT;
                        state_in = btmx_pkg::S_IDLE;
                     end else begin
                        node_in = cand;
                        rd_addr = cand;
                        opp_try_in = 1'b1;
                        state_in = btmx_pkg::S_CHECK_WT;
                     end
                  end
               end
               default: begin
                  // Query: parent in par_ff once the child read is under way.
                  if (!opp_try_ff) begin
                     par_in  = rd_data_ff;
                     cand    = (kb ^ first_ff) ? lz : lo; // root check reads zero side first
                     if (first_ff) cand = lz;
                     else cand = kb ? lz : lo;
                     rd_addr = cand;
                     if (cand == '0) begin
                        // Opposite (or root zero side) absent.
                        opp_try_in = 1'b0;
                        if (first_ff) begin
                           cand = lo;
                           rd_addr = lo;
                           if (lo == '0) begin
                              out_v_in = 1'b1; out_x_in = '0;
                              out_s_in = btmx_pkg::ST_EMPTY;
                              state_in = btmx_pkg::S_IDLE;
                           end else begin
                              bad_in = 1'b1; // zero side already known unusable
                              node_in = lo; opp_try_in = 1'b1;
                              state_in = btmx_pkg::S_CHECK_WT;
                           end
                        end else begin
                           cand = kb ? lo : lz;
                           if (cand == '0) begin
                              out_v_in = 1'b1; out_x_in = acc_ff; out_s_in = btmx_pkg::ST_OK;
                              state_in = btmx_pkg::S_IDLE;
                           end else begin
                              node_in = cand;
                              rd_addr = cand;
                              lvl_in = lvl_ff - 1'b1;
                              if (lvl_ff == LB'(1)) begin
                                 out_v_in = 1'b1; out_x_in = acc_ff;
                                 out_s_in = btmx_pkg::ST_OK;
                                 state_in = btmx_pkg::S_IDLE;
                              end else begin
                                 state_in = btmx_pkg::S_CHECK_WT;
                              end
                           end
                        end
                     end else begin
                        node_in = cand; opp_try_in = 1'b1; bad_in = 1'b0;
                        state_in = btmx_pkg::S_CHECK_WT;
                     end
                  end else if (first_ff) begin
                     // Root emptiness check on zero side (bad_ff clear) or one side.
                     opp_try_in = 1'b0;
                     if (lc != '0) begin
                        first_in = 1'b0; node_in = '0; rd_addr = '0;
                        rd_addr = '0;
                        state_in = btmx_pkg::S_CHECK_RD;
                     end else if (!bad_ff && par_ff[CB +: NB] != '0) begin
                        bad_in = 1'b1; node_in = par_ff[CB +: NB];
                        rd_addr = par_ff[CB +: NB]; opp_try_in = 1'b1;
                        state_in = btmx_pkg::S_CHECK_WT;
                     end else begin
                        out_v_in = 1'b1; out_x_in = '0; out_s_in = btmx_pkg::ST_EMPTY;
                        state_in = btmx_pkg::S_IDLE;
                     end
                  end else begin
                     // rd_data_ff is the opposite child.
                     opp_try_in = 1'b0;
                     if (lc != '0) begin
                        acc_in = acc_ff | (KB'(1) << bidx);
                        lvl_in = lvl_ff - 1'b1;
                        if (lvl_ff == LB'(1)) begin
                           out_v_in = 1'b1; out_x_in = acc_ff | (KB'(1) << bidx);
                           out_s_in = btmx_pkg::ST_OK;
                           state_in = btmx_pkg::S_IDLE;
                        end else begin
                           state_in = btmx_pkg::S_CHECK;
                        end
                     end else begin
                        cand = kb ? par_ff[CB +: NB] : par_ff[CB+NB +: NB];
                        if (cand == '0) begin
                           out_v_in = 1'b1; out_x_in = acc_ff; out_s_in = btmx_pkg::ST_OK;
                           state_in = btmx_pkg::S_IDLE;
                        end else begin
                           node_in = cand; rd_addr = cand;
                           lvl_in = lvl_ff - 1'b1;
                           if (lvl_ff == LB'(1)) begin
                              out_v_in = 1'b1; out_x_in = acc_ff;
                              out_s_in = btmx_pkg::ST_OK;
                              state_in = btmx_pkg::S_IDLE;
                           end else begin
                              state_in = btmx_pkg::S_CHECK_WT;
                           end
                        end
                     end
                  end
               end
            endcase
         end
         btmx_pkg::S_APPLY_RD: begin
            rd_addr  = node_ff;
            state_in = btmx_pkg::S_APPLY_WT;
         end
         btmx_pkg::S_APPLY_WT: begin
            state_in = btmx_pkg::S_APPLY;
         end
         btmx_pkg::S_APPLY: begin
            // Update the count of node_ff (root excluded), then link to the child.
            we = (node_ff != '0) || (cur_ff.kind == btmx_pkg::KIND_ADD && (kb ? lo : lz) == '0);
            wr_addr = node_ff;
            wr_data = rd_data_ff;
            if (node_ff != '0) begin
               if (cur_ff.kind == btmx_pkg::KIND_ADD)
                  wr_data[CB-1:0] = (lc == btmx_pkg::COUNT_MAX) ? lc : lc + 1'b1;
               else
                  wr_data[CB-1:0] = lc - 1'b1;
            end
            cand = kb ? lo : lz;
            if (lvl_ff == '0) begin
               out_v_in = 1'b1; out_x_in = '0; out_s_in = btmx_pkg::ST_OK;
               state_in = btmx_pkg::S_IDLE;
            end else if (cur_ff.kind == btmx_pkg::KIND_ADD && cand == '0) begin
               // Fresh node: link it and set up its word as empty with count 0.
               if (kb) wr_data[CB +: NB] = alloc; else wr_data[CB+NB +: NB] = alloc;
               free_in  = free_ff + 1'b1;
               node_in  = alloc;
               lvl_in   = lvl_ff - 1'b1;
               state_in = btmx_pkg::S_DONE;
            end else begin
               node_in  = cand;
               lvl_in   = lvl_ff - 1'b1;
               state_in = btmx_pkg::S_APPLY_RD;
            end
         end
         btmx_pkg::S_DONE: begin
            // Clear the freshly allocated node, then continue with it as zero data.
            we = 1'b1; wr_addr = node_ff; wr_data = '0;
            state_in = btmx_pkg::S_APPLY_RD;
         end
         default: state_in = btmx_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= btmx_pkg::S_INIT;
         init_ff  <= '0;
         free_ff  <= FB'(KB + 1);
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         init_ff  <= init_in;
         free_ff  <= free_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      node_ff    <= node_in;
      lvl_ff     <= lvl_in;
      acc_ff     <= acc_in;
      first_ff   <= first_in;
      bad_ff     <= bad_in;
      par_ff     <= par_in;
      opp_try_ff <= opp_try_in;
      out_x_ff   <= out_x_in;
      out_s_ff   <= out_s_in;
   end

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !rsp_tready) |=> $stable(out_x_ff) && $stable(out_s_ff))
      else $error("result changed while stalled");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      cmd_ready |-> state_ff == btmx_pkg::S_IDLE)
      else $error("command taken while busy");
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= FB'(btmx_pkg::NODES))
      else $error("free pointer past pool");
   a_query_zero: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && out_s_ff != btmx_pkg::ST_OK) |-> out_x_ff == '0)
      else $error("failed result carries data");
`endif

endmodule

@@ src/binary_trie_max_xor_multiset.sv @@
// Top level of the binary trie max-xor multiset block.
// Instantiates btmx_front and btmx_back; uses btmx_pkg.
//
// This block keeps a multiset of 32-bit keys as a binary trie in a 4096-node
// on-chip memory and answers one result transfer per request transfer. After
// reset a clearing pass seeds the pool with the single key zero; the walker
// takes no command from the queue during it. An add or remove walks the key
// twice (a check pass, then an update pass); a query walks once with up to
// two reads per level. The pace is set by the node memory with one read port,
// one write port and a registered read. A two-entry request queue lets the
// sender run ahead of the walk, and the result register holds its value until
// the receiver takes it.
module binary_trie_max_xor_multiset (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // key[31:0]
   input  logic [1:0]  req_tuser,   // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // best_xor[31:0], status[33:32], zero fill
);

   // Commands flow from the front queue to the trie walker.
   logic               cmd_valid;
   logic               cmd_ready;
   btmx_pkg::cmd_type  cmd;

   btmx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   btmx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
